// ===== rtl/core/ces_pkg.sv =====
package ces_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int QUEUE_DEPTH    = 2;

	localparam int FRAC_BITS = 14;
	localparam int R2_FX     = 23170;

	localparam logic [11:0] FW_RESET = 12'd640;
	localparam logic [12:0] FH_RESET = 13'd480;

	localparam int ROW_OUT_W = 12;
	localparam int COL_OUT_W = 11;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef logic [23:0] pixel_t;

	typedef struct packed {
		pixel_t tl;
		pixel_t tc;
		pixel_t tr;
		pixel_t cl;
		pixel_t cr;
		pixel_t bl;
		pixel_t bc;
		pixel_t br;
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
		logic frame_end;
	} win_item_t;

	typedef struct packed {
		logic we;
		logic idx;
		logic [12:0] data;
	} cfg_wr_t;

endpackage

// ===== rtl/core/ces_ram.sv =====
module ces_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/ces_front.sv =====
module ces_front #(
	parameter int MAX_WIDTH  = ces_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ces_pkg::MAX_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ces_pkg::cfg_wr_t   cfg,
	output logic [11:0]        frame_width,
	output logic [12:0]        frame_height,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [23:0]        s_tdata,
	output logic               push,
	output ces_pkg::win_item_t item,
	input  logic               full
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	typedef enum logic {F_TAKE, F_UPDATE} fstate_t;

	fstate_t          st_q;
	logic [11:0]      fw_q;
	logic [12:0]      fh_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	ces_pkg::pixel_t  px_q;
	ces_pkg::pixel_t  w1_q [3];
	ces_pkg::pixel_t  w2_q [3];
	logic [CW-1:0]    wlast;
	logic [RW-1:0]    hlast;
	logic [47:0]      rdata;
	logic [47:0]      wdata;
	logic             we;
	logic             emit;

	always_comb begin
		int fw;
		int fh;
		fw = int'(fw_q);
		fh = int'(fh_q);
		if (fw < 3) begin
			wlast = CW'(2);
		end else if (fw > MAX_WIDTH) begin
			wlast = CW'(MAX_WIDTH - 1);
		end else begin
			wlast = CW'(fw - 1);
		end
		if (fh < 3) begin
			hlast = RW'(2);
		end else if (fh > MAX_HEIGHT) begin
			hlast = RW'(MAX_HEIGHT - 1);
		end else begin
			hlast = RW'(fh - 1);
		end
	end

	assign frame_width  = fw_q;
	assign frame_height = fh_q;
	assign s_tready     = (st_q == F_TAKE) && !full;
	assign we           = (st_q == F_UPDATE);
	assign wdata        = {px_q, rdata[47:24]};
	assign emit         = (row_q >= RW'(2)) && (col_q >= CW'(2));
	assign push         = we && emit;

	// rdata: [47:24] row above, [23:0] two rows above
	ces_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (we),
		.waddr (col_q),
		.wdata (wdata),
		.raddr (col_q),
		.rdata (rdata)
	);

	always_comb begin
		item.tl        = w1_q[0];
		item.tc        = w2_q[0];
		item.tr        = rdata[23:0];
		item.cl        = w1_q[1];
		item.cr        = rdata[47:24];
		item.bl        = w1_q[2];
		item.bc        = w2_q[2];
		item.br        = px_q;
		item.row       = ces_pkg::ROW_OUT_W'(row_q - RW'(1));
		item.col       = ces_pkg::COL_OUT_W'(col_q - CW'(1));
		item.frame_end = (row_q >= hlast) && (col_q >= wlast);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= F_TAKE;
			fw_q  <= ces_pkg::FW_RESET;
			fh_q  <= ces_pkg::FH_RESET;
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 3; i++) begin
				w1_q[i] <= '0;
				w2_q[i] <= '0;
			end
		end else begin
			case (st_q)
				F_TAKE: begin
					if (s_tvalid && s_tready) begin
						st_q <= F_UPDATE;
					end
				end
				F_UPDATE: begin
					st_q <= F_TAKE;
					w1_q[0] <= w2_q[0];
					w1_q[1] <= w2_q[1];
					w1_q[2] <= w2_q[2];
					w2_q[0] <= rdata[23:0];
					w2_q[1] <= rdata[47:24];
					w2_q[2] <= px_q;
					if (col_q >= wlast) begin
						col_q <= '0;
						row_q <= (row_q >= hlast) ? '0 : row_q + RW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				default: st_q <= F_TAKE;
			endcase
			if (cfg.we) begin
				if (cfg.idx == ces_pkg::REG_FRAME_WIDTH) begin
					fw_q <= cfg.data[11:0];
				end else begin
					fh_q <= cfg.data;
				end
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			px_q <= s_tdata;
		end
	end

endmodule

// ===== rtl/core/ces_fifo.sv =====
module ces_fifo #(
	parameter int DEPTH = ces_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ces_pkg::win_item_t wr_data,
	output logic               full,
	input  logic               pop,
	output logic               rd_valid,
	output ces_pkg::win_item_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	ces_pkg::win_item_t mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [NW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (cnt_q == NW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/core/ces_isqrt.sv =====
module ces_isqrt #(
	parameter int W = 50
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   value,
	output logic           done,
	output logic [W/2-1:0] root
);

	localparam int QW = W / 2;
	localparam int RW = QW + 3;
	localparam int CW = $clog2(QW + 1);

	logic [W-1:0]  val_q;
	logic [RW-1:0] rem_q;
	logic [QW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic          ge;

	assign rem_sh = {rem_q[RW-3:0], val_q[W-1 -: 2]};
	assign trial  = RW'({root_q, 2'b01});
	assign ge     = (rem_sh >= trial);
	assign done   = done_q;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[QW-2:0], ge};
		end
	end

endmodule

// ===== rtl/core/ces_back.sv =====
module ces_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  ces_pkg::win_item_t q_data,
	output logic               q_pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,
	output logic               m_tlast
);

	localparam int SQW = 50;
	localparam int DVW = 33;

	typedef enum logic [3:0] {
		S_IDLE, S_GRAD, S_SQX, S_SQY, S_MSTART, S_MWAIT,
		S_CUBE1, S_CUBE2, S_DIV, S_FSTART, S_FWAIT, S_OUT
	} bstate_t;

	localparam logic signed [15:0] R2 = 16'(ces_pkg::R2_FX);

	bstate_t            st_q;
	ces_pkg::win_item_t it_q;
	logic [1:0]         k_q;
	logic signed [24:0] gx_q;
	logic signed [24:0] gy_q;
	logic [SQW-1:0]     sq_q;
	logic [10:0]        max_q;
	logic [12:0]        sum_q;
	logic [21:0]        mm_q;
	logic [DVW-1:0]     dvd_q;
	logic [13:0]        rem_q;
	logic [5:0]         cnt_q;
	logic [7:0]         res_q;

	logic signed [9:0]  dx, dy;
	logic signed [10:0] ds, dd;
	logic signed [26:0] mx, my, gx27, gy27;
	logic signed [49:0] px2;
	logic [SQW-1:0]     sq_sum;
	logic [13:0]        rem_sh;
	logic               ge;
	logic               rt_start;
	logic [SQW-1:0]     rt_val;
	logic               rt_done;
	logic [SQW/2-1:0]   rt_root;
	logic [10:0]        mag;

	function automatic logic [7:0] chan(input ces_pkg::pixel_t p, input logic [1:0] k);
		return p[k*8 +: 8];
	endfunction

	always_comb begin
		dx   = signed'({2'b00, chan(it_q.cr, k_q)}) - signed'({2'b00, chan(it_q.cl, k_q)});
		dy   = signed'({2'b00, chan(it_q.bc, k_q)}) - signed'({2'b00, chan(it_q.tc, k_q)});
		ds   = signed'({3'b000, chan(it_q.br, k_q)}) - signed'({3'b000, chan(it_q.tl, k_q)})
		     + signed'({3'b000, chan(it_q.tr, k_q)}) - signed'({3'b000, chan(it_q.bl, k_q)});
		dd   = signed'({3'b000, chan(it_q.br, k_q)}) - signed'({3'b000, chan(it_q.tl, k_q)})
		     - signed'({3'b000, chan(it_q.tr, k_q)}) + signed'({3'b000, chan(it_q.bl, k_q)});
		mx   = R2 * ds;
		my   = R2 * dd;
		gx27 = (27'(dx) <<< ces_pkg::FRAC_BITS) + mx;
		gy27 = (27'(dy) <<< ces_pkg::FRAC_BITS) + my;
	end

	assign px2    = (st_q == S_SQX) ? gx_q * gx_q : gy_q * gy_q;
	assign sq_sum = sq_q + unsigned'(px2);
	assign rem_sh = {rem_q[12:0], dvd_q[DVW-1]};
	assign ge     = (rem_sh >= {1'b0, sum_q});
	assign mag    = rt_root[ces_pkg::FRAC_BITS +: 11];

	assign rt_start = (st_q == S_MSTART) || (st_q == S_FSTART);
	assign rt_val   = (st_q == S_FSTART) ? SQW'(dvd_q) : sq_q;

	ces_isqrt #(.W(SQW)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rt_start),
		.value  (rt_val),
		.done   (rt_done),
		.root   (rt_root)
	);

	assign q_pop    = (st_q == S_IDLE) && q_valid;
	assign m_tvalid = (st_q == S_OUT);
	// m_tdata: edge_res [7:0], out_row [19:8], out_col [30:20], zero [31]
	assign m_tdata  = {1'b0, it_q.col, it_q.row, res_q};
	assign m_tlast  = it_q.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			k_q   <= '0;
			cnt_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						k_q  <= '0;
						st_q <= S_GRAD;
					end
				end
				S_GRAD:   st_q <= S_SQX;
				S_SQX:    st_q <= S_SQY;
				S_SQY:    st_q <= S_MSTART;
				S_MSTART: st_q <= S_MWAIT;
				S_MWAIT: begin
					if (rt_done) begin
						if (k_q == 2'd2) begin
							st_q <= S_CUBE1;
						end else begin
							k_q  <= k_q + 2'd1;
							st_q <= S_GRAD;
						end
					end
				end
				S_CUBE1: st_q <= (sum_q == '0) ? S_OUT : S_CUBE2;
				S_CUBE2: begin
					cnt_q <= 6'(DVW);
					st_q  <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						st_q <= S_FSTART;
					end
				end
				S_FSTART: st_q <= S_FWAIT;
				S_FWAIT: begin
					if (rt_done) begin
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				it_q  <= q_data;
				max_q <= '0;
				sum_q <= '0;
			end
			S_GRAD: begin
				gx_q <= gx27[24:0];
				gy_q <= gy27[24:0];
			end
			S_SQX: sq_q <= unsigned'(px2);
			S_SQY: sq_q <= sq_sum;
			S_MWAIT: begin
				if (rt_done) begin
					if (mag > max_q) begin
						max_q <= mag;
					end
					sum_q <= sum_q + 13'(mag);
				end
			end
			S_CUBE1: begin
				mm_q  <= max_q * max_q;
				res_q <= '0;
			end
			S_CUBE2: begin
				dvd_q <= mm_q * max_q;
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= ge ? rem_sh - {1'b0, sum_q} : rem_sh;
				dvd_q <= {dvd_q[DVW-2:0], ge};
			end
			S_FWAIT: begin
				if (rt_done) begin
					res_q <= (rt_root > (SQW/2)'(255)) ? 8'd255 : rt_root[7:0];
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/color_edge_strength_3x3_core.sv =====
// Colour edge strength over a 3x3 neighborhood.
// Input stream: one BGR pixel per transaction in raster order, s_tdata = {red, green, blue}.
// Output stream: one transaction per interior pixel (border pixels give none);
// m_tlast marks the last interior pixel of the frame.
// APB: frame_width at 0x0, frame_height at 0x4; a write restarts the frame position.
// Write configuration only while the block is idle.
// Front end takes a pixel and reads the line store, then updates window and line store
// before it can take another pixel; it hands windows to a 2-entry queue. Back end, per
// channel, runs a 25-step bit-serial square root, then a 33-step divider and one more
// 25-step square root, all on one shared root unit (divider and last root are skipped
// when all magnitudes are 0). It takes a new window only after m_tready takes the result.
// A stall on m_tready holds the result; the front keeps accepting until the queue fills.
// Reset clears window, counters and queue and loads 640 x 480; line stores are not
// cleared and need no clearing pass.
module color_edge_strength_3x3_core #(
	parameter int MAX_WIDTH  = ces_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ces_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // blue [7:0], green [15:8], red [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // edge_res [7:0], out_row [19:8], out_col [30:20]
	output logic        m_tlast
);

	ces_pkg::cfg_wr_t   cfg;
	ces_pkg::win_item_t push_item;
	ces_pkg::win_item_t pop_item;
	logic [11:0]        fw;
	logic [12:0]        fh;
	logic               push;
	logic               full;
	logic               pop;
	logic               pop_valid;

	assign pready   = 1'b1;
	assign cfg.we   = psel && penable && pwrite && pready;
	assign cfg.idx  = paddr[2];
	assign cfg.data = pwdata[12:0];
	assign prdata   = (paddr[2] == ces_pkg::REG_FRAME_HEIGHT) ? {19'd0, fh} : {20'd0, fw};

	ces_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.frame_width  (fw),
		.frame_height (fh),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.push         (push),
		.item         (push_item),
		.full         (full)
	);

	ces_fifo #(.DEPTH(ces_pkg::QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (push_item),
		.full     (full),
		.pop      (pop),
		.rd_valid (pop_valid),
		.rd_data  (pop_item)
	);

	ces_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (pop_valid),
		.q_data   (pop_item),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/core/ces_checker.sv =====
module ces_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("m_tdata changed under stall");

	a_front_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("front took two pixels back to back");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19:8] != 12'd0) && (m_tdata[30:20] != 11'd0) && !m_tdata[31])
		else $error("result outside interior");

endmodule

bind color_edge_strength_3x3_core ces_checker u_ces_checker (.*);
